// File: rtl/core/four_to_two_audio_matrix_mixer_macros.svh
// assertion macros for the four-to-two audio matrix mixer
`ifndef FOUR_TO_TWO_AUDIO_MATRIX_MIXER_MACROS_SVH
`define FOUR_TO_TWO_AUDIO_MATRIX_MIXER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FTTM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define FTTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> cons) \
        else $error("assertion failed");
`else
`define FTTM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define FTTM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/fttm_pkg.sv
// shared types, constants and coefficient table for the audio matrix mixer
`timescale 1ns / 1ps
package fttm_pkg;

    typedef logic signed [31:0] t_sample;
    typedef logic signed [48:0] t_prod;
    typedef logic signed [51:0] t_acc;
    typedef logic signed [15:0] t_out;
    typedef logic [16:0]        t_coef;
    typedef logic [2:0]         t_mode;

    localparam t_mode MODE_PASS       = 3'd0;
    localparam t_mode MODE_STEREO_C3  = 3'd1;
    localparam t_mode MODE_COMM_C3    = 3'd2;
    localparam t_mode MODE_COMM_C4    = 3'd3;
    localparam t_mode MODE_SPREAD     = 3'd4;

    localparam t_coef Q_ZERO = 17'd0;
    localparam t_coef Q_HALF = 17'd32768;
    localparam t_coef Q_0707 = 17'd46334;
    localparam t_coef Q_0866 = 17'd56754;
    localparam t_coef Q_ONE  = 17'd65536;

    localparam int HEADROOM = 5;

    // clip bounds: (2^31 - 1 - headroom) * 2^16 and (-2^31 + headroom) * 2^16
    localparam t_acc CLIP_HI = t_acc'((64'sd2147483647 - 64'(HEADROOM)) * 64'sd65536);
    localparam t_acc CLIP_LO = t_acc'((-64'sd2147483648 + 64'(HEADROOM)) * 64'sd65536);

    localparam logic ROW_LEFT  = 1'b0;
    localparam logic ROW_RIGHT = 1'b1;

    function automatic t_coef mix_coef(input t_mode mode, input logic row, input logic [1:0] ch);
        t_coef l [4];
        t_coef r [4];
        begin
            l = '{Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO};
            r = '{Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO};
            case (mode)
                MODE_PASS: begin
                end
                MODE_STEREO_C3: begin
                    l = '{Q_0707, Q_0707, Q_ZERO, Q_ZERO};
                    r = '{Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO};
                end
                MODE_COMM_C3: begin
                    l = '{Q_ONE, Q_ZERO, Q_0707, Q_ZERO};
                    r = '{Q_ZERO, Q_ONE, Q_0707, Q_ZERO};
                end
                MODE_COMM_C4: begin
                    l = '{Q_ONE, Q_ZERO, Q_ZERO, Q_0707};
                    r = '{Q_ZERO, Q_ONE, Q_ZERO, Q_0707};
                end
                MODE_SPREAD: begin
                    l = '{Q_ONE, Q_ZERO, Q_0866, Q_HALF};
                    r = '{Q_ZERO, Q_ONE, Q_HALF, Q_0866};
                end
                default: begin
                end
            endcase
            mix_coef = (row == ROW_RIGHT) ? r[ch] : l[ch];
        end
    endfunction

endpackage

// File: rtl/core/fttm_prod.sv
// product stage: four coefficient-times-sample products for one output row
`timescale 1ns / 1ps
module fttm_prod (
    input  logic             i_clk,
    input  fttm_pkg::t_mode  i_mode,
    input  logic             i_row,
    input  fttm_pkg::t_sample i_smp [4],
    output fttm_pkg::t_prod  o_prod [4]
);
    import fttm_pkg::*;

    t_prod r_prod [4];
    t_prod n_prod [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_prod[i] = t_prod'(i_smp[i])
                      * t_prod'($signed({1'b0, mix_coef(i_mode, i_row, 2'(i))}));
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/core/fttm_clip.sv
// sum, clip and scale stage for one output row
`timescale 1ns / 1ps
module fttm_clip (
    input  logic           i_clk,
    input  fttm_pkg::t_prod i_prod [4],
    output fttm_pkg::t_out o_out
);
    import fttm_pkg::*;

    t_acc acc;
    t_acc clipped;
    logic rnd;
    t_out n_out;
    t_out r_out;

    always_comb begin
        acc = t_acc'(i_prod[0]) + t_acc'(i_prod[1]) + t_acc'(i_prod[2]) + t_acc'(i_prod[3]);
        if (acc > CLIP_HI) begin
            clipped = CLIP_HI;
        end else if (acc < CLIP_LO) begin
            clipped = CLIP_LO;
        end else begin
            clipped = acc;
        end
        // divide by 2^32 toward zero: floor shift, then bump negatives with a remainder
        rnd   = clipped[51] && (|clipped[31:0]);
        n_out = t_out'(clipped[47:32] + {15'd0, rnd});
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out = r_out;

endmodule

// File: rtl/core/four_to_two_audio_matrix_mixer.sv
// results strobe once the accepted transaction has passed every pipeline register
// throughput: one sample set per cycle; busy stays low, nothing stalls
// pipeline: input register, product register, sum/clip/scale register
// the receiver cannot stall, so each result is shown for one cycle only
// synchronous active-low reset clears valid flags and sets mix mode to pass-through
`timescale 1ns / 1ps
`include "four_to_two_audio_matrix_mixer_macros.svh"
module four_to_two_audio_matrix_mixer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  fttm_pkg::t_sample   i_ch1_sample,
    input  fttm_pkg::t_sample   i_ch2_sample,
    input  fttm_pkg::t_sample   i_ch3_sample,
    input  fttm_pkg::t_sample   i_ch4_sample,
    input  logic                i_last_set,
    output logic                o_strobe,
    output fttm_pkg::t_out      o_left_out,
    output fttm_pkg::t_out      o_right_out,
    output logic                o_last_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  fttm_pkg::t_mode     i_cfg_data
);
    import fttm_pkg::*;

    t_mode   r_mode;
    t_sample r_smp [4];
    logic    r_v0, r_v1, r_v2;
    logic    r_last0, r_last1, r_last2;
    t_prod   prod_l [4];
    t_prod   prod_r [4];
    logic    accept;
    logic    cfg_wr;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PASS;
        end else if (cfg_wr && (i_cfg_data <= MODE_SPREAD)) begin
            r_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_smp   <= '{i_ch1_sample, i_ch2_sample, i_ch3_sample, i_ch4_sample};
        end
        r_last0 <= i_last_set;
        r_last1 <= r_last0;
        r_last2 <= r_last1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= accept;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    fttm_prod u_prod_l (
        .i_clk  (i_clk),
        .i_mode (r_mode),
        .i_row  (ROW_LEFT),
        .i_smp  (r_smp),
        .o_prod (prod_l)
    );

    fttm_prod u_prod_r (
        .i_clk  (i_clk),
        .i_mode (r_mode),
        .i_row  (ROW_RIGHT),
        .i_smp  (r_smp),
        .o_prod (prod_r)
    );

    fttm_clip u_clip_l (
        .i_clk  (i_clk),
        .i_prod (prod_l),
        .o_out  (o_left_out)
    );

    fttm_clip u_clip_r (
        .i_clk  (i_clk),
        .i_prod (prod_r),
        .o_out  (o_right_out)
    );

    assign o_strobe   = r_v2;
    assign o_last_out = r_last2;

    `FTTM_ASSERT_NEXT(a_latency, i_clk, i_rst_n, accept, ##2 o_strobe)
    `FTTM_ASSERT_IMPLIES(a_no_min, i_clk, i_rst_n, o_strobe, (o_left_out != 16'sh8000) && (o_right_out != 16'sh8000))
    `FTTM_ASSERT_NEXT(a_bad_mode, i_clk, i_rst_n, cfg_wr && (i_cfg_data > MODE_SPREAD), $stable(r_mode))

endmodule

// File: bench/tb.sv
// testbench for the four-to-two audio matrix mixer: a directed table, then random sets per mix mode
`timescale 1ns / 1ps
module tb;
    import fttm_pkg::*;

    localparam int     SETS_PER_PHASE = 650;
    localparam int     CYCLE_LIMIT    = 200000;
    localparam int     NUM_DIRECTED   = 21;
    localparam t_mode  MODE_BAD_LO    = 3'd5;
    localparam t_mode  MODE_BAD_MID   = 3'd6;
    localparam t_mode  MODE_BAD_HI    = 3'd7;
    localparam t_sample S_MAX         = 32'sh7FFFFFFF;
    localparam t_sample S_MIN         = 32'sh80000000;
    localparam longint SUM_HI = (64'sd2147483647 - 64'(HEADROOM)) * 64'sd65536;
    localparam longint SUM_LO = (-64'sd2147483648 + 64'(HEADROOM)) * 64'sd65536;

    typedef struct packed {
        t_out left;
        t_out right;
        logic last;
    } mix_result_t;

    // one row of directed stimulus; known rows carry the mix typed in
    typedef struct packed {
        logic    cfg_wr;
        t_mode   cfg_val;
        t_sample c1;
        t_sample c2;
        t_sample c3;
        t_sample c4;
        logic    last;
        logic    known;
        t_out    exp_l;
        t_out    exp_r;
    } mix_case_t;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_sample i_ch1_sample = '0;
    t_sample i_ch2_sample = '0;
    t_sample i_ch3_sample = '0;
    t_sample i_ch4_sample = '0;
    logic    i_last_set = 1'b0;
    logic    o_strobe;
    t_out    o_left_out;
    t_out    o_right_out;
    logic    o_last_out;
    logic    i_cfg_valid = 1'b0;
    logic    o_cfg_ready;
    t_mode   i_cfg_data = MODE_PASS;

    mix_result_t pending_mix[$];
    mix_case_t   directed_cases[NUM_DIRECTED];
    t_mode       mode_model = MODE_PASS;
    int          idle_pct = 0;
    int          fail_count = 0;
    int          cycle_count = 0;

    four_to_two_audio_matrix_mixer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_ch1_sample (i_ch1_sample),
        .i_ch2_sample (i_ch2_sample),
        .i_ch3_sample (i_ch3_sample),
        .i_ch4_sample (i_ch4_sample),
        .i_last_set   (i_last_set),
        .o_strobe     (o_strobe),
        .o_left_out   (o_left_out),
        .o_right_out  (o_right_out),
        .o_last_out   (o_last_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // clip the Q16 sum, then drop 32 bits truncating toward zero
    function automatic t_out clip_scale(input longint acc);
        longint sat;
        begin
            sat = acc;
            if (sat > SUM_HI) begin
                sat = SUM_HI;
            end else if (sat < SUM_LO) begin
                sat = SUM_LO;
            end
            clip_scale = t_out'(sat / 64'sd4294967296);
        end
    endfunction

    function automatic mix_result_t downmix(input t_mode mode, input t_sample a, input t_sample b,
                                            input t_sample c, input t_sample d, input logic last);
        longint l_coef[4];
        longint r_coef[4];
        longint smp[4];
        longint acc_l;
        longint acc_r;
        mix_result_t res;
        begin
            l_coef = '{longint'(Q_ONE), 0, 0, 0};
            r_coef = '{0, longint'(Q_ONE), 0, 0};
            case (mode)
                MODE_STEREO_C3: begin
                    l_coef = '{longint'(Q_0707), longint'(Q_0707), 0, 0};
                    r_coef = '{0, 0, longint'(Q_ONE), 0};
                end
                MODE_COMM_C3: begin
                    l_coef[2] = longint'(Q_0707);
                    r_coef[2] = longint'(Q_0707);
                end
                MODE_COMM_C4: begin
                    l_coef[3] = longint'(Q_0707);
                    r_coef[3] = longint'(Q_0707);
                end
                MODE_SPREAD: begin
                    l_coef[2] = longint'(Q_0866);
                    l_coef[3] = longint'(Q_HALF);
                    r_coef[2] = longint'(Q_HALF);
                    r_coef[3] = longint'(Q_0866);
                end
                default: begin
                end
            endcase
            smp = '{longint'(a), longint'(b), longint'(c), longint'(d)};
            acc_l = 0;
            acc_r = 0;
            for (int i = 0; i < 4; i++) begin
                acc_l += l_coef[i] * smp[i];
                acc_r += r_coef[i] * smp[i];
            end
            res.left = clip_scale(acc_l);
            res.right = clip_scale(acc_r);
            res.last = last;
            downmix = res;
        end
    endfunction

    function automatic t_sample rand_sample();
        t_sample s;
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: s = t_sample'($urandom);
                4, 5: s = t_sample'(int'($urandom_range(0, 2097152)) - 1048576);
                6: s = $urandom_range(0, 1) ? S_MAX : S_MIN;
                7: s = $urandom_range(0, 1) ? S_MAX - t_sample'($urandom_range(0, 10))
                                            : S_MIN + t_sample'($urandom_range(0, 10));
                default: s = t_sample'(int'($urandom) >>> $urandom_range(0, 30));
            endcase
            rand_sample = s;
        end
    endfunction

    task automatic send_set(input t_sample a, input t_sample b, input t_sample c,
                            input t_sample d, input logic last, input logic known,
                            input t_out exp_l, input t_out exp_r);
        mix_result_t want;
        begin
            while ($urandom_range(0, 99) < idle_pct) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
            start <= 1'b1;
            i_ch1_sample <= a;
            i_ch2_sample <= b;
            i_ch3_sample <= c;
            i_ch4_sample <= d;
            i_last_set <= last;
            do @(posedge i_clk); while (busy);
            if (known) begin
                want.left = exp_l;
                want.right = exp_r;
                want.last = last;
            end else begin
                want = downmix(mode_model, a, b, c, d, last);
            end
            pending_mix.push_back(want);
        end
    endtask

    // only written with the pipeline empty
    task automatic write_mode(input t_mode val);
        begin
            start <= 1'b0;
            while (pending_mix.size() != 0) @(posedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_data <= val;
            do @(posedge i_clk); while (!o_cfg_ready);
            i_cfg_valid <= 1'b0;
            if (val <= MODE_SPREAD) begin
                mode_model = val;
            end
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("four_to_two_audio_matrix_mixer regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin : result_check
        mix_result_t want;
        if (i_rst_n && o_strobe) begin
            if (pending_mix.size() == 0) begin
                $display("%0t: unexpected result L=%0d R=%0d last=%0b", $time,
                         o_left_out, o_right_out, o_last_out);
                fail_count++;
            end else begin
                want = pending_mix.pop_front();
                if (o_left_out !== want.left) begin
                    $display("%0t: left expected %0d actual %0d", $time, want.left, o_left_out);
                    fail_count++;
                end
                if (o_right_out !== want.right) begin
                    $display("%0t: right expected %0d actual %0d", $time, want.right,
                             o_right_out);
                    fail_count++;
                end
                if (o_last_out !== want.last) begin
                    $display("%0t: last expected %0b actual %0b", $time, want.last, o_last_out);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int left_in_phase;
        int seg_len;
        mix_case_t row;
        directed_cases = '{
            '{1'b0, MODE_PASS, 0, 0, 0, 0, 1'b0, 1'b1, 0, 0},
            '{1'b0, MODE_PASS, S_MAX, S_MIN, 0, 0, 1'b1, 1'b1, 32767, -32767},
            // just under one output step truncates to zero both ways
            '{1'b0, MODE_PASS, 65535, -65535, S_MAX, S_MIN, 1'b0, 1'b1, 0, 0},
            '{1'b0, MODE_PASS, 65536, -65536, 0, 0, 1'b1, 1'b1, 1, -1},
            // right on the clip bounds
            '{1'b0, MODE_PASS, S_MAX - 5, S_MIN + 5, 0, 0, 1'b0, 1'b1, 32767, -32767},
            // out-of-range mode is dropped, pass-through stays
            '{1'b1, MODE_BAD_HI, 131072, 0, S_MAX, S_MAX, 1'b0, 1'b1, 2, 0},
            '{1'b1, MODE_STEREO_C3, S_MAX, S_MAX, S_MIN, 0, 1'b1, 1'b1, 32767, -32767},
            '{1'b0, MODE_PASS, 123456789, -987654321, 55555, -1, 1'b0, 1'b0, 0, 0},
            '{1'b0, MODE_PASS, -1, -1, -1, -1, 1'b1, 1'b0, 0, 0},
            '{1'b1, MODE_COMM_C3, S_MAX, S_MAX, S_MAX, S_MIN, 1'b0, 1'b1, 32767, 32767},
            '{1'b0, MODE_PASS, S_MIN, S_MIN, S_MIN, S_MAX, 1'b1, 1'b1, -32767, -32767},
            '{1'b1, MODE_BAD_LO, 32'sh12345678, -32'sh12345678, 32'sh40000000, 0,
              1'b0, 1'b0, 0, 0},
            '{1'b1, MODE_COMM_C4, 1000000, -2000000, S_MAX, S_MIN, 1'b0, 1'b0, 0, 0},
            '{1'b0, MODE_PASS, S_MAX, S_MIN, 0, S_MAX, 1'b1, 1'b0, 0, 0},
            '{1'b1, MODE_BAD_MID, -7777777, 8888888, 0, S_MIN, 1'b0, 1'b0, 0, 0},
            '{1'b1, MODE_SPREAD, S_MAX, S_MAX, S_MAX, S_MAX, 1'b0, 1'b1, 32767, 32767},
            '{1'b0, MODE_PASS, S_MIN, S_MIN, S_MIN, S_MIN, 1'b1, 1'b1, -32767, -32767},
            '{1'b0, MODE_PASS, 0, 0, 0, 0, 1'b0, 1'b1, 0, 0},
            '{1'b0, MODE_PASS, S_MAX, S_MIN, S_MIN, S_MAX, 1'b0, 1'b0, 0, 0},
            '{1'b0, MODE_PASS, 0, 0, 32'sh40000000, -32'sh40000000, 1'b1, 1'b0, 0, 0},
            '{1'b1, MODE_PASS, -131072, 131071, 0, 0, 1'b0, 1'b1, -2, 1}
        };
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 6;
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            row = directed_cases[i];
            if (row.cfg_wr) begin
                write_mode(row.cfg_val);
            end
            send_set(row.c1, row.c2, row.c3, row.c4, row.last, row.known,
                     row.exp_l, row.exp_r);
        end

        // sender gaps: light, then heavy, then none
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 6 : (phase == 1) ? 79 : 0;
            left_in_phase = SETS_PER_PHASE;
            while (left_in_phase > 0) begin
                seg_len = $urandom_range(40, 120);
                if (seg_len > left_in_phase) begin
                    seg_len = left_in_phase;
                end
                write_mode(t_mode'($urandom_range(0, 7)));
                for (int k = 0; k < seg_len; k++) begin
                    send_set(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                             1'($urandom_range(0, 1)), 1'b0, 0, 0);
                end
                left_in_phase -= seg_len;
            end
        end
        start <= 1'b0;

        while (pending_mix.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("four_to_two_audio_matrix_mixer regression: pass");
        end else begin
            $display("four_to_two_audio_matrix_mixer regression: fail");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/fttm_pkg.sv
rtl/core/fttm_prod.sv
rtl/core/fttm_clip.sv
rtl/core/four_to_two_audio_matrix_mixer.sv
bench/tb.sv
